@@ rtl/core/tdfa_pkg.sv @@
package tdfa_pkg;

  // automaton size and derived table geometry
  localparam int NUM_STATES  = 16;
  localparam int STATE_W     = 4;
  localparam int SYM_W       = 8;
  localparam int IDX_W       = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int ADDR_W      = IDX_W + SYM_W;
  localparam int TABLE_DEPTH = NUM_STATES * (2 ** SYM_W);

  // configuration register width and indexes
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_3  = 3'd5;

  // item modes
  localparam logic MODE_CHAR  = 1'b0;
  localparam logic MODE_TABLE = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_REJECT = 2'd1;
  localparam logic [1:0] VERDICT_ERROR  = 2'd2;

  // one transition table entry
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] dest;
  } entry_t;

  // table access request from the control path
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } tbl_req_t;

  // configuration seen by the control path
  typedef struct packed {
    logic [STATE_W-1:0]      start_state;
    logic [2**STATE_W-1:0]   accept_mask;
  } cfg_view_t;

endpackage

@@ rtl/core/table_driven_dfa_acceptor_core.sv @@
// Programmable automaton acceptor. After reset the transition table (NUM_STATES x 256
// entries) is swept to all-invalid, one entry a cycle; in_stall stays high during the
// sweep, and configuration writes are taken at any time. Afterwards one item is taken
// every cycle while in_stall is low: a table write goes straight into the table memory,
// a character reads the entry for its state and symbol in the cycle it is accepted and
// resolves the next state from the read data in the following cycle, which feeds the
// address of the next character's read. The verdict of a string is registered from the
// read stage into the result word once its last character resolves; while a verdict
// word is stalled, a further last character waits in the read stage with in_stall high.
// The loop from table read data to next read address through the single memory read
// port sets the item rate.
module table_driven_dfa_acceptor_core import tdfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic                  in_last,
  input  logic [STATE_W-1:0]    in_from_state,
  input  logic [STATE_W-1:0]    in_to_state,
  input  logic                  in_entry_valid,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_verdict,
  output logic [STATE_W-1:0]    out_final_state
);

  cfg_view_t cfg_view;
  logic      in_alpha;
  tbl_req_t  tbl_req;
  entry_t    rd_data;
  logic      tbl_ready;

  // configuration registers and alphabet check
  tdfa_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .symbol_i   (in_symbol),
    .view_o     (cfg_view),
    .in_alpha_o (in_alpha)
  );

  // transition table memory
  tdfa_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (tbl_req),
    .rd_data_o (rd_data),
    .ready_o   (tbl_ready)
  );

  // string tracking and result word
  tdfa_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_symbol       (in_symbol),
    .in_last         (in_last),
    .in_from_state   (in_from_state),
    .in_to_state     (in_to_state),
    .in_entry_valid  (in_entry_valid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_final_state (out_final_state),
    .cfg_i           (cfg_view),
    .in_alpha_i      (in_alpha),
    .tbl_ready_i     (tbl_ready),
    .rd_data_i       (rd_data),
    .tbl_req_o       (tbl_req)
  );

endmodule

@@ rtl/core/tdfa_cfg.sv @@
module tdfa_cfg import tdfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SYM_W-1:0]      symbol_i,
  output cfg_view_t             view_o,
  output logic                  in_alpha_o
);

  logic [STATE_W-1:0]    start_state_r;
  logic [2**STATE_W-1:0] accept_mask_r;
  logic [4*CFG_DATA_W-1:0] alphabet_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
      alphabet_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_STATE: start_state_r <= cfg_wdata[STATE_W-1:0];
        CFG_ACCEPT_MASK: accept_mask_r <= cfg_wdata[2**STATE_W-1:0];
        CFG_ALPHABET_0:  alphabet_r[CFG_DATA_W-1:0] <= cfg_wdata;
        CFG_ALPHABET_1:  alphabet_r[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_wdata;
        CFG_ALPHABET_2:  alphabet_r[3*CFG_DATA_W-1:2*CFG_DATA_W] <= cfg_wdata;
        CFG_ALPHABET_3:  alphabet_r[4*CFG_DATA_W-1:3*CFG_DATA_W] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // alphabet membership of the incoming character
  assign in_alpha_o = alphabet_r[symbol_i];

  assign view_o.start_state = start_state_r;
  assign view_o.accept_mask = accept_mask_r;

endmodule

@@ rtl/core/tdfa_table.sv @@
module tdfa_table import tdfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req_i,
  output entry_t   rd_data_o,
  output logic     ready_o
);

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data_r;
  logic              clearing_r, clearing_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_last;

  // clearing sweep after reset
  assign clr_last = (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1));

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_last) clearing_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_r <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_r;
  assign ready_o   = !clearing_r;

  // no traffic from the control path during the sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !req_i.wr_en && !req_i.rd_en)
    else $error("table access during clearing sweep");

  // sweep ends right after the last entry
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r && clr_last |=> ready_o)
    else $error("clearing sweep did not end");

endmodule

@@ rtl/core/tdfa_ctrl.sv @@
module tdfa_ctrl import tdfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic               in_last,
  input  logic [STATE_W-1:0] in_from_state,
  input  logic [STATE_W-1:0] in_to_state,
  input  logic               in_entry_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_verdict,
  output logic [STATE_W-1:0] out_final_state,
  input  cfg_view_t          cfg_i,
  input  logic               in_alpha_i,
  input  logic               tbl_ready_i,
  input  entry_t             rd_data_i,
  output tbl_req_t           tbl_req_o
);

  // committed string state
  logic [STATE_W-1:0] cur_state_r;
  logic               err_r;
  logic               in_string_r;

  // character waiting for its table read
  logic               p_valid_r;
  logic               p_last_r;
  logic               p_err_r;
  logic               p_lookup_r;
  logic [STATE_W-1:0] p_state_r;

  // result word
  logic               out_valid_r;
  logic [1:0]         out_verdict_r;
  logic [STATE_W-1:0] out_final_state_r;

  logic [STATE_W-1:0] res_state;
  logic               res_err;
  logic               res_in_str;
  logic               p_hold;
  logic               in_acc;
  logic               char_acc;
  logic [STATE_W-1:0] base_state;
  logic               base_err;
  logic               new_err;
  logic               lookup;
  logic               out_load;
  logic [1:0]         verdict;

  // resolve the pending character against the table read data
  always_comb begin
    res_state  = cur_state_r;
    res_err    = err_r;
    res_in_str = in_string_r;
    if (p_valid_r) begin
      res_state  = (p_lookup_r && rd_data_i.valid) ? rd_data_i.dest : p_state_r;
      res_err    = p_err_r;
      res_in_str = !p_last_r;
    end
  end

  // hold the pending last character while the result word is blocked
  assign p_hold   = p_valid_r && p_last_r && out_valid_r && out_stall;
  assign in_stall = !tbl_ready_i || p_hold;
  assign in_acc   = in_valid && !in_stall;
  assign char_acc = in_acc && (in_mode == MODE_CHAR);

  // state the new character starts from
  assign base_state = res_in_str ? res_state : cfg_i.start_state;
  assign base_err   = res_in_str && res_err;
  assign new_err    = base_err || !in_alpha_i;
  assign lookup     = !new_err && (32'(base_state) < NUM_STATES);

  // table read for characters, table write for entries
  always_comb begin
    tbl_req_o.rd_en        = char_acc && lookup;
    tbl_req_o.rd_addr      = {IDX_W'(base_state), in_symbol};
    tbl_req_o.wr_en        = in_acc && (in_mode == MODE_TABLE)
                             && (32'(in_from_state) < NUM_STATES);
    tbl_req_o.wr_addr      = {IDX_W'(in_from_state), in_symbol};
    tbl_req_o.wr_data.valid = in_entry_valid;
    tbl_req_o.wr_data.dest  = in_entry_valid ? in_to_state : '0;
  end

  // verdict of a finished string
  assign out_load = p_valid_r && p_last_r && !p_hold;

  always_comb begin
    if (p_err_r) begin
      verdict = VERDICT_ERROR;
    end else if (cfg_i.accept_mask[res_state]) begin
      verdict = VERDICT_ACCEPT;
    end else begin
      verdict = VERDICT_REJECT;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      err_r       <= 1'b0;
      in_string_r <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!p_hold) begin
        cur_state_r <= res_state;
        err_r       <= res_err;
        in_string_r <= res_in_str;
        p_valid_r   <= char_acc;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (char_acc) begin
      p_last_r   <= in_last;
      p_err_r    <= new_err;
      p_lookup_r <= lookup;
      p_state_r  <= base_state;
    end
    if (out_load) begin
      out_verdict_r     <= verdict;
      out_final_state_r <= res_state;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = out_verdict_r;
  assign out_final_state = out_final_state_r;

  // an accepted character always occupies the read stage next
  assert property (@(posedge clk) disable iff (!rst_n)
    char_acc |=> p_valid_r)
    else $error("accepted character lost");

  // a blocked last character keeps its state
  assert property (@(posedge clk) disable iff (!rst_n)
    p_hold |=> p_valid_r && p_last_r && $stable(p_state_r))
    else $error("held character changed");

  // no table traffic while a finished string waits
  assert property (@(posedge clk) disable iff (!rst_n)
    p_hold |-> !tbl_req_o.rd_en && !tbl_req_o.wr_en)
    else $error("table access while stalled");

endmodule

@@ sim/table_driven_dfa_acceptor_core_test.sv @@
module table_driven_dfa_acceptor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdfa_pkg::*;

  // register indexes past the end of the register file
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // cycles with no handshake on either side before giving up
  localparam int QUIET_LIMIT = 20000;
  localparam int NUM_PHASES  = 10;

  typedef struct packed {
    logic               mode;
    logic [SYM_W-1:0]   symbol;
    logic               last;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               entry_valid;
  } dfa_word_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic [STATE_W-1:0] final_state;
  } dfa_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = MODE_CHAR;
  logic [SYM_W-1:0]      in_symbol = '0;
  logic                  in_last = 1'b0;
  logic [STATE_W-1:0]    in_from_state = '0;
  logic [STATE_W-1:0]    in_to_state = '0;
  logic                  in_entry_valid = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_verdict;
  logic [STATE_W-1:0]    out_final_state;

  // words waiting to be sent and verdicts waiting to arrive
  dfa_word_t    word_q[$];
  dfa_verdict_t verdict_q[$];

  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // automaton mirror: configuration, string state and transition table
  logic [STATE_W-1:0]    m_start;
  logic [2**STATE_W-1:0] m_accept;
  logic [255:0]          m_alphabet;
  logic [STATE_W-1:0]    m_state;
  logic                  m_error;
  logic                  m_open;
  entry_t                m_table [TABLE_DEPTH];

  table_driven_dfa_acceptor_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_symbol       (in_symbol),
    .in_last         (in_last),
    .in_from_state   (in_from_state),
    .in_to_state     (in_to_state),
    .in_entry_valid  (in_entry_valid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_final_state (out_final_state)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the automaton mirror by one accepted word
  function automatic void step_automaton(input dfa_word_t w);
    entry_t       e;
    dfa_verdict_t r;
    if (w.mode == MODE_TABLE) begin
      if (w.from_state < NUM_STATES) begin
        e.valid = w.entry_valid;
        e.dest  = w.entry_valid ? w.to_state : '0;
        m_table[{w.from_state, w.symbol}] = e;
      end
      return;
    end
    // first character of a string starts from the start state
    if (!m_open) begin
      m_state = m_start;
      m_error = 1'b0;
    end
    // characters after an error are dropped
    if (!m_error) begin
      if (!m_alphabet[w.symbol]) begin
        m_error = 1'b1;
      end else if (m_state < NUM_STATES) begin
        e = m_table[{m_state, w.symbol}];
        if (e.valid) m_state = e.dest;
      end
    end
    if (!w.last) begin
      m_open = 1'b1;
      return;
    end
    if (m_error) r.verdict = VERDICT_ERROR;
    else if (m_accept[m_state]) r.verdict = VERDICT_ACCEPT;
    else r.verdict = VERDICT_REJECT;
    r.final_state = m_state;
    verdict_q = {verdict_q, r};
    m_open  = 1'b0;
    m_error = 1'b0;
    m_state = m_start;
  endfunction

  function automatic void push_char(input logic [SYM_W-1:0] c, input logic l);
    dfa_word_t w;
    w.mode        = MODE_CHAR;
    w.symbol      = c;
    w.last        = l;
    w.from_state  = STATE_W'($urandom_range(15));
    w.to_state    = STATE_W'($urandom_range(15));
    w.entry_valid = 1'($urandom_range(1));
    word_q = {word_q, w};
  endfunction

  function automatic void push_entry(input logic [STATE_W-1:0] from, input logic [SYM_W-1:0] c,
                                     input logic [STATE_W-1:0] to, input logic v, input logic l);
    dfa_word_t w;
    w.mode        = MODE_TABLE;
    w.symbol      = c;
    w.last        = l;
    w.from_state  = from;
    w.to_state    = to;
    w.entry_valid = v;
    word_q = {word_q, w};
  endfunction

  // register write, mirrored right away since nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_START_STATE: m_start = data[STATE_W-1:0];
      CFG_ACCEPT_MASK: m_accept = data[2**STATE_W-1:0];
      CFG_ALPHABET_0:  m_alphabet[63:0] = data;
      CFG_ALPHABET_1:  m_alphabet[127:64] = data;
      CFG_ALPHABET_2:  m_alphabet[191:128] = data;
      CFG_ALPHABET_3:  m_alphabet[255:192] = data;
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [STATE_W-1:0] st, input logic [15:0] acc,
                            input logic [255:0] alpha);
    write_reg(CFG_START_STATE, CFG_DATA_W'(st));
    write_reg(CFG_ACCEPT_MASK, CFG_DATA_W'(acc));
    write_reg(CFG_ALPHABET_0, alpha[63:0]);
    write_reg(CFG_ALPHABET_1, alpha[127:64]);
    write_reg(CFG_ALPHABET_2, alpha[191:128]);
    write_reg(CFG_ALPHABET_3, alpha[255:192]);
    close_writes();
  endtask

  // hold the sender until every word is taken and every verdict is back
  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  // one random phase: new settings, a programmed table, then strings
  task automatic run_phase(input int ph);
    logic [SYM_W-1:0]   syms [4];
    logic [255:0]       alpha;
    logic [STATE_W-1:0] st;
    logic [15:0]        acc;
    logic [SYM_W-1:0]   c;
    int                 budget;
    int                 count;
    int                 len;
    int                 roll;
    int                 t;
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
    foreach (syms[k]) syms[k] = SYM_W'($urandom_range(255));
    st  = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : 4'($urandom_range(15));
    acc = (ph == 2) ? 16'h0000 : (ph == 4) ? 16'hffff : 16'($urandom);
    // sparse alphabet holding the working symbols; phase 5 empties it and phase 6 fills it
    for (int k = 0; k < 8; k++) alpha[k*32 +: 32] = $urandom & $urandom;
    foreach (syms[k]) alpha[syms[k]] = 1'b1;
    if (ph == 5) alpha = '0;
    if (ph == 6) alpha = '1;
    set_config(st, acc, alpha);
    budget = (ph == 5) ? 60 : 170;
    // program every state for the working symbols
    for (int s = 0; s < NUM_STATES; s++) begin
      foreach (syms[k]) begin
        push_entry(STATE_W'(s), syms[k], STATE_W'($urandom_range(15)),
                   $urandom_range(99) < 85, 1'($urandom_range(1)));
      end
    end
    count = NUM_STATES * 4;
    while (count < budget) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        // occasional table rewrite in the middle of a string
        if ($urandom_range(99) < 4) begin
          push_entry(STATE_W'($urandom_range(15)), syms[2'($urandom_range(3))],
                     STATE_W'($urandom_range(15)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
          count++;
        end
        roll = $urandom_range(99);
        if (roll < 88) begin
          c = syms[2'($urandom_range(3))];
        end else if (roll < 94) begin
          c = SYM_W'($urandom_range(255));
        end else begin
          c = SYM_W'($urandom_range(255));
          for (t = 0; t < 16 && m_alphabet[c]; t++) c = SYM_W'($urandom_range(255));
        end
        push_char(c, i == len - 1);
        count++;
      end
    end
    drain();
  endtask

  // driver: present the next queued word once the current one is taken
  always @(posedge clk) begin : feed
    dfa_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = word_q.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= nxt.mode;
        in_symbol      <= nxt.symbol;
        in_last        <= nxt.last;
        in_from_state  <= nxt.from_state;
        in_to_state    <= nxt.to_state;
        in_entry_valid <= nxt.entry_valid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict from accepted words, check accepted verdicts
  always @(posedge clk) begin : observe
    dfa_word_t    seen;
    dfa_verdict_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen.mode        = in_mode;
        seen.symbol      = in_symbol;
        seen.last        = in_last;
        seen.from_state  = in_from_state;
        seen.to_state    = in_to_state;
        seen.entry_valid = in_entry_valid;
        step_automaton(seen);
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected word: verdict %0d final_state %0d", out_verdict, out_final_state);
          failures++;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
            failures++;
          end
          if (out_final_state !== want.final_state) begin
            $error("final_state: expected %0d, got %0d", want.final_state, out_final_state);
            failures++;
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("table_driven_dfa_acceptor_core regression: fail");
    $finish;
  end

  initial begin
    foreach (m_table[i]) m_table[i] = '0;
    m_start    = '0;
    m_accept   = '0;
    m_alphabet = '0;
    m_state    = '0;
    m_error    = 1'b0;
    m_open     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty alphabet after reset: any character is an error
    push_char(8'h00, 1'b1);
    drain();

    // small hand-built automaton, spare register indexes must be ignored
    set_config(4'd3, 16'h0010, {64'h8000_0000_0000_0008, 64'h1, 64'h2, 64'h1});
    write_reg(CFG_SPARE_6, '1);
    write_reg(CFG_SPARE_7, '1);
    close_writes();
    push_entry(4'd3, 8'h00, 4'd4, 1'b1, 1'b0);
    push_entry(4'd4, 8'hff, 4'd15, 1'b1, 1'b0);
    push_entry(4'd15, 8'h41, 4'd4, 1'b1, 1'b0);
    push_entry(4'd4, 8'h41, 4'd7, 1'b1, 1'b0);
    // later write removes the entry
    push_entry(4'd4, 8'h41, 4'd0, 1'b0, 1'b0);
    // table write flagged last gives no verdict
    push_entry(4'd3, 8'hc3, 4'd0, 1'b1, 1'b1);
    push_char(8'h00, 1'b1);
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b1);
    // missing transition keeps the state
    push_char(8'h41, 1'b1);
    push_char(8'h00, 1'b0);
    push_char(8'h41, 1'b1);
    // out-of-alphabet character, later characters ignored
    push_char(8'h00, 1'b0);
    push_char(8'h12, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b1);
    push_char(8'h80, 1'b0);
    push_char(8'hc3, 1'b1);
    // start state changed in the middle of a string
    push_char(8'h00, 1'b0);
    drain();
    write_reg(CFG_START_STATE, CFG_DATA_W'(4'd15));
    close_writes();
    push_char(8'hff, 1'b1);
    push_char(8'h41, 1'b1);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);

    if (failures == 0) begin
      $display("table_driven_dfa_acceptor_core regression: pass");
    end else begin
      $display("table_driven_dfa_acceptor_core regression: fail");
    end
    $finish;
  end

endmodule
